>>> src/dcc_pkg.sv
`timescale 1ns / 1ps

package dcc_pkg;

  localparam int DEF_MAX_NODES = 64;
  localparam int DEF_MAX_EDGES = 256;

  localparam int OP_W    = 2;
  localparam int NODE_W  = 6;
  localparam int RAW_W   = 21;
  localparam int CNT_W   = 9;
  localparam int NC_W    = 7;
  localparam int ERR_W   = 2;
  localparam int VAL_W   = 32;
  localparam int STR_W   = 16;

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH  = 2'd1;
  localparam logic [OP_W-1:0] OP_POP   = 2'd2;
  localparam logic [OP_W-1:0] OP_CHECK = 2'd3;

  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;
  localparam logic [ERR_W-1:0] ERR_EDGE  = 2'd3;

  typedef struct packed {
    logic latch;
    logic clr_start;
    logic clr_step;
    logic push;
    logic pop;
    logic chk_start;
    logic edge_rd;
    logic dist_rd;
    logic sum;
    logic cmp;
    logic pass_new;
    logic verify_new;
    logic chk_end;
    logic chk_ok;
    logic res_load;
  } dcc_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            sweep_last;
    logic            k_end;
    logic            pass_last;
    logic            changed;
    logic            apply;
    logic            lt;
  } dcc_sts_t;

endpackage

>>> src/dcc_channels.sv
`timescale 1ns / 1ps

interface dcc_req_if;
  logic                                valid;
  logic                                ready;
  logic [dcc_pkg::OP_W-1:0]            op;
  logic [dcc_pkg::NODE_W-1:0]          from_node;
  logic [dcc_pkg::NODE_W-1:0]          to_node;
  logic signed [dcc_pkg::RAW_W-1:0]    raw_bound;

  modport source (output valid, op, from_node, to_node, raw_bound, input ready);
  modport sink (input valid, op, from_node, to_node, raw_bound, output ready);
endinterface

interface dcc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        consistent;
  logic [dcc_pkg::ERR_W-1:0]   error;
  logic [dcc_pkg::CNT_W-1:0]   edge_count;

  modport source (output valid, consistent, error, edge_count, input ready);
  modport sink (input valid, consistent, error, edge_count, output ready);
endinterface

interface dcc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [dcc_pkg::NC_W-1:0]   node_count;

  modport source (output valid, node_count, input ready);
  modport sink (input valid, node_count, output ready);
endinterface

>>> src/difference_constraint_consistency_unit.sv
// push and pop pass from acceptance through S_OP to S_DONE; clear sweeps all MAX_NODES distances
// check: relaxes every held edge once per pass, for up to clamped node_count + 1 passes
// each edge relaxation steps through S_EDGE, S_DIST, S_SUM and S_CMP via the memory ports
// one transaction in flight at a time; the next is taken while a result waits at the output
// reset: edge stack empty, node_count 1, then a sweep over all MAX_NODES entries zeroes the distances
// during which no transaction is accepted; configuration writes are taken at any time
`timescale 1ns / 1ps

module difference_constraint_consistency_unit #(
  parameter int MAX_NODES = dcc_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = dcc_pkg::DEF_MAX_EDGES
) (
  input logic       clk,
  input logic       rst,
  dcc_req_if.sink   req,
  dcc_rsp_if.source rsp,
  dcc_cfg_if.sink   cfg
);
  import dcc_pkg::*;

  dcc_cmd_t cmd;
  dcc_sts_t sts;

  assign cfg.ready = 1'b1;

  dcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dcc_datapath #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg.valid && cfg.ready),
    .cfg_node_count (cfg.node_count),
    .op             (req.op),
    .from_node      (req.from_node),
    .to_node        (req.to_node),
    .raw_bound      (req.raw_bound),
    .cmd            (cmd),
    .sts            (sts),
    .consistent     (rsp.consistent),
    .error          (rsp.error),
    .edge_count     (rsp.edge_count)
  );

endmodule

>>> src/dcc_ctrl.sv
`timescale 1ns / 1ps

module dcc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  dcc_pkg::dcc_sts_t sts,
  output dcc_pkg::dcc_cmd_t cmd
);
  import dcc_pkg::*;

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_OP   = 4'd2;
  localparam logic [3:0] S_CLR  = 4'd3;
  localparam logic [3:0] S_EDGE = 4'd4;
  localparam logic [3:0] S_DIST = 4'd5;
  localparam logic [3:0] S_SUM  = 4'd6;
  localparam logic [3:0] S_CMP  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_valid;
  logic       out_valid_next;

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = out_valid;

  always_comb begin
    cmd            = '0;
    state_next     = state;
    out_valid_next = out_valid && !rsp_ready;
    case (state)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_OP;
        end
      end
      S_OP: begin
        case (sts.op)
          OP_CLEAR: begin
            cmd.clr_start = 1'b1;
            state_next    = S_CLR;
          end
          OP_PUSH: begin
            cmd.push   = 1'b1;
            state_next = S_DONE;
          end
          OP_POP: begin
            cmd.pop    = 1'b1;
            state_next = S_DONE;
          end
          OP_CHECK: begin
            cmd.chk_start = 1'b1;
            state_next    = S_EDGE;
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_DONE;
        end
      end
      S_EDGE: begin
        if (sts.k_end) begin
          if (sts.apply && sts.changed && !sts.pass_last) begin
            cmd.pass_new = 1'b1;
          end else if (sts.apply && sts.changed) begin
            cmd.verify_new = 1'b1;
          end else begin
            cmd.chk_end = 1'b1;
            cmd.chk_ok  = 1'b1;
            state_next  = S_DONE;
          end
        end else begin
          cmd.edge_rd = 1'b1;
          state_next  = S_DIST;
        end
      end
      S_DIST: begin
        cmd.dist_rd = 1'b1;
        state_next  = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_CMP;
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        if (!sts.apply && sts.lt) begin
          cmd.chk_end = 1'b1;
          state_next  = S_DONE;
        end else begin
          state_next = S_EDGE;
        end
      end
      S_DONE: begin
        if (!out_valid || rsp_ready) begin
          cmd.res_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> src/dcc_datapath.sv
`timescale 1ns / 1ps

module dcc_datapath #(
  parameter int MAX_NODES = dcc_pkg::DEF_MAX_NODES,
  parameter int MAX_EDGES = dcc_pkg::DEF_MAX_EDGES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [dcc_pkg::NC_W-1:0]         cfg_node_count,
  input  logic [dcc_pkg::OP_W-1:0]         op,
  input  logic [dcc_pkg::NODE_W-1:0]       from_node,
  input  logic [dcc_pkg::NODE_W-1:0]       to_node,
  input  logic signed [dcc_pkg::RAW_W-1:0] raw_bound,
  input  dcc_pkg::dcc_cmd_t                cmd,
  output dcc_pkg::dcc_sts_t                sts,
  output logic                             consistent,
  output logic [dcc_pkg::ERR_W-1:0]        error,
  output logic [dcc_pkg::CNT_W-1:0]        edge_count
);
  import dcc_pkg::*;

  localparam int NW  = $clog2(MAX_NODES);
  localparam int AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int NCW = ($clog2(MAX_NODES + 1) > NC_W) ? $clog2(MAX_NODES + 1) : NC_W;

  typedef struct packed {
    logic [NW-1:0]    src;
    logic [NW-1:0]    dst;
    logic [RAW_W-1:0] raw;
  } edge_rec_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [STR_W-1:0]        strict;
  } dist_t;

  edge_rec_t edge_mem [MAX_EDGES];
  dist_t     dist_mem [MAX_NODES];

  logic [NC_W-1:0]         node_count;
  logic [OP_W-1:0]         op_q;
  logic [NODE_W-1:0]       from_q;
  logic [NODE_W-1:0]       to_q;
  logic [RAW_W-1:0]        raw_q;
  logic [EW-1:0]           held;
  logic [EW-1:0]           k;
  logic [NCW-1:0]          passes;
  logic                    changed;
  logic                    apply;
  logic [NW-1:0]           sweep;
  edge_rec_t               edge_q;
  dist_t                   src_q;
  dist_t                   dst_q;
  logic signed [VAL_W-1:0] sum_val;
  logic [STR_W-1:0]        sum_st;
  logic                    cons_r;
  logic [ERR_W-1:0]        err_r;

  logic [NCW-1:0]          nc_ext;
  logic [NCW-1:0]          eff;
  logic                    full;
  logic                    empty;
  logic                    bad;
  logic                    push_ok;
  logic signed [VAL_W:0]   sum_wide;
  logic [STR_W:0]          st_wide;
  logic signed [VAL_W-1:0] sum_sat;
  logic [STR_W-1:0]        st_sat;
  logic                    lt;
  logic [NW-1:0]           wr_addr;
  dist_t                   wr_data;
  logic                    wr_en;

  // effective node count
  assign nc_ext = NCW'(node_count);
  assign eff    = (nc_ext == '0) ? NCW'(1) :
                  ((nc_ext > NCW'(MAX_NODES)) ? NCW'(MAX_NODES) : nc_ext);

  assign full    = (held == EW'(MAX_EDGES));
  assign empty   = (held == '0);
  assign bad     = (from_q == to_q) || (NCW'(from_q) >= eff) || (NCW'(to_q) >= eff);
  assign push_ok = !full && !bad;

  // relaxation sum with saturation
  assign sum_wide = {src_q.value[VAL_W-1], src_q.value} +
                    {{(VAL_W + 1 - (RAW_W - 1)){edge_q.raw[RAW_W-1]}}, edge_q.raw[RAW_W-1:1]};
  assign st_wide  = {1'b0, src_q.strict} + (STR_W + 1)'(!edge_q.raw[0]);
  assign sum_sat  = (sum_wide[VAL_W] != sum_wide[VAL_W-1]) ?
                    (sum_wide[VAL_W] ? {1'b1, {(VAL_W - 1){1'b0}}} : {1'b0, {(VAL_W - 1){1'b1}}}) :
                    sum_wide[VAL_W-1:0];
  assign st_sat   = st_wide[STR_W] ? {STR_W{1'b1}} : st_wide[STR_W-1:0];

  assign lt = (sum_val < dst_q.value) || ((sum_val == dst_q.value) && (sum_st > dst_q.strict));

  assign sts.op         = op_q;
  assign sts.sweep_last = (sweep == NW'(MAX_NODES - 1));
  assign sts.k_end      = (k == held);
  assign sts.pass_last  = (passes == NCW'(1));
  assign sts.changed    = changed;
  assign sts.apply      = apply;
  assign sts.lt         = lt;

  // distance write port
  assign wr_en   = cmd.clr_step || (cmd.cmp && lt && apply);
  assign wr_addr = cmd.clr_step ? sweep : edge_q.dst;
  assign wr_data = cmd.clr_step ? dist_t'('0) : {sum_val, sum_st};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      dist_mem[wr_addr] <= wr_data;
    end
    if (cmd.dist_rd) begin
      src_q <= dist_mem[edge_q.src];
      dst_q <= dist_mem[edge_q.dst];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && push_ok) begin
      edge_mem[held[AW-1:0]] <= {NW'(from_q), NW'(to_q), raw_q};
    end
    if (cmd.edge_rd) begin
      edge_q <= edge_mem[k[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NC_W'(1);
      held       <= '0;
      sweep      <= '0;
      k          <= '0;
      passes     <= '0;
      changed    <= 1'b0;
      apply      <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count <= cfg_node_count;
      end
      if (cmd.clr_start) begin
        held <= '0;
      end else if (cmd.push && push_ok) begin
        held <= held + EW'(1);
      end else if (cmd.pop && !empty) begin
        held <= held - EW'(1);
      end
      if (cmd.clr_start) begin
        sweep <= '0;
      end else if (cmd.clr_step) begin
        sweep <= sweep + NW'(1);
      end
      if (cmd.chk_start) begin
        k       <= '0;
        passes  <= eff;
        changed <= 1'b0;
        apply   <= 1'b1;
      end else if (cmd.pass_new) begin
        k       <= '0;
        passes  <= passes - NCW'(1);
        changed <= 1'b0;
      end else if (cmd.verify_new) begin
        k     <= '0;
        apply <= 1'b0;
      end else if (cmd.cmp) begin
        k <= k + EW'(1);
        if (lt) begin
          changed <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q   <= op;
      from_q <= from_node;
      to_q   <= to_node;
      raw_q  <= raw_bound;
      cons_r <= 1'b0;
      err_r  <= ERR_OK;
    end
    if (cmd.push) begin
      if (full) begin
        err_r <= ERR_FULL;
      end else if (bad) begin
        err_r <= ERR_EDGE;
      end
    end
    if (cmd.pop && empty) begin
      err_r <= ERR_EMPTY;
    end
    if (cmd.chk_end) begin
      cons_r <= cmd.chk_ok;
    end
    if (cmd.sum) begin
      sum_val <= sum_sat;
      sum_st  <= st_sat;
    end
    if (cmd.res_load) begin
      consistent <= cons_r;
      error      <= err_r;
      edge_count <= CNT_W'(held);
    end
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import dcc_pkg::*;

  localparam int STALL_LIMIT = 250000;
  localparam int DRAIN_CYCLES = 2 * DEF_MAX_NODES + 16;
  localparam longint VAL_MAX = 64'sd2147483647;
  localparam longint VAL_MIN = -64'sd2147483648;
  localparam int unsigned STRICT_MAX = 65535;
  localparam logic [RAW_W-1:0] RAW_MAX = 21'h0FFFFF;
  localparam logic [RAW_W-1:0] RAW_MIN = 21'h100000;

  typedef struct {
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    logic [RAW_W-1:0]  raw;
  } arc_t;

  typedef struct packed {
    logic             consistent;
    logic [ERR_W-1:0] error;
    logic [CNT_W-1:0] edge_count;
  } outcome_t;

  logic clk;
  logic rst;

  dcc_req_if req_ch ();
  dcc_rsp_if rsp_ch ();
  dcc_cfg_if cfg_ch ();

  difference_constraint_consistency_unit i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  arc_t            arc_stack [DEF_MAX_EDGES];
  int unsigned     arcs_held;
  int              dist_val [DEF_MAX_NODES];
  int unsigned     dist_strk [DEF_MAX_NODES];
  logic [NC_W-1:0] nodes_cfg;

  outcome_t    expected_outcomes [$];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned ready_hold;
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned checks_run;
  int unsigned cycles_found;
  int unsigned err_seen [4];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned live_nodes();
    if (nodes_cfg == 0) return 1;
    if (nodes_cfg > DEF_MAX_NODES) return DEF_MAX_NODES;
    return nodes_cfg;
  endfunction

  function automatic void clear_graph();
    arcs_held = 0;
    foreach (dist_val[i]) begin
      dist_val[i] = 0;
      dist_strk[i] = 0;
    end
  endfunction

  function automatic bit relax_arc(int unsigned k, bit apply);
    int unsigned             s;
    int unsigned             d;
    logic signed [RAW_W-1:0] rb;
    longint                  sum_v;
    int unsigned             sum_s;
    bit                      lower;
    s = arc_stack[k].src;
    d = arc_stack[k].dst;
    rb = arc_stack[k].raw;
    sum_v = dist_val[s];
    sum_v = sum_v + (rb >>> 1);
    sum_s = dist_strk[s] + (rb[0] ? 0 : 1);
    if (sum_v > VAL_MAX) sum_v = VAL_MAX;
    if (sum_v < VAL_MIN) sum_v = VAL_MIN;
    if (sum_s > STRICT_MAX) sum_s = STRICT_MAX;
    lower = (sum_v < dist_val[d]) || (sum_v == dist_val[d] && sum_s > dist_strk[d]);
    if (lower && apply) begin
      dist_val[d] = int'(sum_v);
      dist_strk[d] = sum_s;
    end
    return lower;
  endfunction

  function automatic bit find_consistency();
    int unsigned passes;
    bit          moved;
    passes = live_nodes();
    do begin
      moved = 1'b0;
      for (int unsigned k = 0; k < arcs_held; k++) begin
        if (relax_arc(k, 1'b1)) moved = 1'b1;
      end
      passes--;
    end while (passes != 0 && moved);
    if (moved) begin
      for (int unsigned k = 0; k < arcs_held; k++) begin
        if (relax_arc(k, 1'b0)) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic outcome_t predict_outcome(logic [OP_W-1:0] op,
      logic [NODE_W-1:0] from_node, logic [NODE_W-1:0] to_node, logic [RAW_W-1:0] raw);
    outcome_t o;
    o = '0;
    case (op)
      OP_CLEAR: begin
        clear_graph();
      end
      OP_PUSH: begin
        if (arcs_held >= DEF_MAX_EDGES) begin
          o.error = ERR_FULL;
        end else if (from_node == to_node || from_node >= live_nodes() ||
                     to_node >= live_nodes()) begin
          o.error = ERR_EDGE;
        end else begin
          arc_stack[arcs_held] = '{src: from_node, dst: to_node, raw: raw};
          arcs_held++;
        end
      end
      OP_POP: begin
        if (arcs_held == 0) o.error = ERR_EMPTY;
        else arcs_held--;
      end
      default: begin
        o.consistent = find_consistency();
      end
    endcase
    o.edge_count = CNT_W'(arcs_held);
    return o;
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  function automatic logic [RAW_W-1:0] pick_raw();
    int unsigned      pick;
    logic [RAW_W-1:0] r;
    pick = $urandom_range(99);
    if (pick < 50) begin
      r = RAW_W'($urandom_range(360) - 60);
    end else if (pick < 80) begin
      r = RAW_W'($urandom);
    end else begin
      case ($urandom_range(3))
        0: begin
          r = RAW_MIN;
        end
        1: begin
          r = RAW_MAX;
        end
        2: begin
          r = '0;
        end
        default: begin
          r = '1;
        end
      endcase
    end
    return r;
  endfunction

  function automatic logic [NC_W-1:0] pick_node_count();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return NC_W'($urandom_range(8, 2));
    if (pick < 65) return NC_W'($urandom_range(16, 2));
    if (pick < 75) return NC_W'(DEF_MAX_NODES);
    if (pick < 85) return NC_W'($urandom_range(127, DEF_MAX_NODES + 1));
    if (pick < 92) return '0;
    return NC_W'(1);
  endfunction

  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    do @(negedge clk); while (expected_outcomes.size() != 0);
  endtask

  task automatic send_item(logic [OP_W-1:0] op, logic [NODE_W-1:0] from_node,
      logic [NODE_W-1:0] to_node, logic [RAW_W-1:0] raw);
    outcome_t o;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.op        <= op;
    req_ch.from_node <= from_node;
    req_ch.to_node   <= to_node;
    req_ch.raw_bound <= raw;
    do @(posedge clk); while (!req_ch.ready);
    o = predict_outcome(op, from_node, to_node, raw);
    expected_outcomes.push_back(o);
    items_sent++;
    err_seen[o.error]++;
    if (op == OP_CHECK) begin
      checks_run++;
      if (!o.consistent) cycles_found++;
    end
    @(negedge clk);
  endtask

  task automatic send_simple(logic [OP_W-1:0] op);
    send_item(op, NODE_W'($urandom_range(63)), NODE_W'($urandom_range(63)),
              RAW_W'($urandom));
  endtask

  task automatic write_node_count(logic [NC_W-1:0] value);
    wait_idle();
    cfg_ch.valid      <= 1'b1;
    cfg_ch.node_count <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    nodes_cfg = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_random_item();
    int unsigned       n;
    int unsigned       cap;
    int unsigned       pick;
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    n = live_nodes();
    cap = (n > 16) ? 10 : 16;
    pick = $urandom_range(99);
    if (pick < 4) begin
      send_simple(OP_CLEAR);
    end else if (pick < 14) begin
      send_item(OP_PUSH, NODE_W'($urandom_range(63)), NODE_W'($urandom_range(63)),
                pick_raw());
    end else if (pick < 26 || arcs_held >= cap) begin
      send_simple(OP_POP);
    end else if (pick < 42) begin
      send_simple(OP_CHECK);
    end else begin
      a = NODE_W'($urandom_range(n - 1));
      b = (n < 2) ? a : NODE_W'((a + 1 + $urandom_range(n - 2)) % n);
      send_item(OP_PUSH, a, b, pick_raw());
    end
  endtask

  task automatic set_pacing(int unsigned sender_pct, int unsigned receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
  endtask

  task automatic test_basic_ops();
    write_node_count(4);
    send_simple(OP_POP);
    send_simple(OP_CHECK);
    send_item(OP_PUSH, 0, 3, RAW_MAX);
    send_item(OP_PUSH, 3, 0, RAW_MIN);
    send_simple(OP_CHECK);
    send_item(OP_PUSH, 2, 2, 21'd4);
    send_item(OP_PUSH, 4, 1, 21'd4);
    send_item(OP_PUSH, 1, 63, 21'd4);
    send_item(OP_PUSH, 63, 0, 21'd4);
    send_simple(OP_POP);
    send_simple(OP_CHECK);
    send_simple(OP_CLEAR);
    // zero weight cycles, weak then strict
    send_item(OP_PUSH, 1, 2, 21'd1);
    send_item(OP_PUSH, 2, 1, 21'd1);
    send_simple(OP_CHECK);
    send_item(OP_PUSH, 1, 2, 21'd0);
    send_item(OP_PUSH, 2, 1, 21'd0);
    send_simple(OP_CHECK);
    send_item(OP_PUSH, 0, 1, 21'h1FFFFF);
    send_simple(OP_CHECK);
    send_simple(OP_CLEAR);
    send_simple(OP_CHECK);
  endtask

  task automatic test_node_count_limits();
    write_node_count(0);
    send_item(OP_PUSH, 0, 1, 21'd6);
    send_item(OP_PUSH, 0, 0, 21'd6);
    write_node_count(127);
    send_item(OP_PUSH, 0, 63, 21'd7);
    send_item(OP_PUSH, 63, 62, 21'h1FFFF0);
    send_simple(OP_CHECK);
    write_node_count(DEF_MAX_NODES);
    send_item(OP_PUSH, 62, 0, 21'd2);
    send_item(OP_PUSH, 63, 63, 21'd2);
    send_simple(OP_CHECK);
    write_node_count(1);
    send_item(OP_PUSH, 1, 0, 21'd3);
    send_simple(OP_CHECK);
    send_simple(OP_CLEAR);
  endtask

  task automatic test_full_stack_saturation();
    write_node_count(DEF_MAX_NODES);
    send_simple(OP_CLEAR);
    // alternating strict edges at the lowest bound drive both distances to the limits
    for (int k = 0; k < DEF_MAX_EDGES; k++) begin
      send_item(OP_PUSH, NODE_W'((k % 2) ? 9 : 5), NODE_W'((k % 2) ? 5 : 9), RAW_MIN);
    end
    send_item(OP_PUSH, 1, 2, 21'd0);
    send_item(OP_PUSH, 7, 7, 21'd0);
    repeat (5) send_simple(OP_CHECK);
    send_simple(OP_POP);
    send_simple(OP_CHECK);
    send_simple(OP_CLEAR);
  endtask

  task automatic test_backpressure();
    write_node_count(8);
    ready_hold = 400;
    repeat (20) send_random_item();
  endtask

  task automatic test_random_traffic(int unsigned items);
    for (int unsigned i = 0; i < items; i++) begin
      if (i % 60 == 0) write_node_count(pick_node_count());
      send_random_item();
    end
  endtask

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (ready_hold != 0) begin
        rsp_ch.ready <= 1'b0;
        ready_hold--;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_results
    outcome_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_outcomes.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual %0d/%0d/%0d", $time,
                 rsp_ch.consistent, rsp_ch.error, rsp_ch.edge_count);
        fail_count++;
      end else begin
        want = expected_outcomes.pop_front();
        compare_field("consistent", want.consistent, rsp_ch.consistent);
        compare_field("error", want.error, rsp_ch.error);
        compare_field("edge_count", want.edge_count, rsp_ch.edge_count);
      end
    end
  end

  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) stalled = 0;
      else stalled++;
    end
    $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.op         = OP_CLEAR;
    req_ch.from_node  = '0;
    req_ch.to_node    = '0;
    req_ch.raw_bound  = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.node_count = 7'd1;
    ready_hold        = 0;
    fail_count        = 0;
    items_sent        = 0;
    checks_run        = 0;
    cycles_found      = 0;
    foreach (err_seen[i]) err_seen[i] = 0;
    nodes_cfg = 7'd1;
    clear_graph();
    set_pacing(6, 73);
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    test_basic_ops();
    test_node_count_limits();
    test_full_stack_saturation();
    test_backpressure();
    test_random_traffic(145);
    set_pacing(73, 6);
    test_random_traffic(145);
    set_pacing(0, 0);
    test_random_traffic(145);

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("run covered %0d transactions, %0d checks, %0d with a negative cycle",
             items_sent, checks_run, cycles_found);
    $display("flagged: %0d full stack, %0d empty stack, %0d invalid edge",
             err_seen[ERR_FULL], err_seen[ERR_EMPTY], err_seen[ERR_EDGE]);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
